### rtl/core/fbd_pkg.sv
// Shared types and constants of the filterbank decimator.
package fbd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int AVG_W          = 24;
    localparam int CHAN_GROUP_W   = 9;
    localparam int SAMP_GROUP_W   = 11;
    localparam int CHANNELS_W     = 13;
    localparam int IFS_W          = 3;
    localparam int POS_W          = 12;
    localparam int IF_W           = 2;
    localparam int GCC_W          = 8;
    localparam int GSC_W          = 10;
    localparam int GSUM_W         = 24;
    localparam int TSUM_W         = 34;
    localparam int STORE_DEPTH    = 16384;
    localparam int ADDR_W         = 14;
    localparam int DIVISOR_W      = 19;
    localparam int QUOT_W         = 24;
    localparam int DIV_CNT_W      = 5;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CHAN_GROUP_W-1:0] MAX_CHAN_GROUP = 9'd256;
    localparam logic [SAMP_GROUP_W-1:0] MAX_SAMP_GROUP = 11'd1024;
    localparam logic [CHANNELS_W-1:0]   MAX_CHANNELS   = 13'd4096;
    localparam logic [IFS_W-1:0]        MAX_IFS        = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NCHAN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NIF   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic take_in;
        logic store_we;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic group_done;
        logic emit_pending;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

### rtl/core/fbd_if.sv
// Stream interfaces for filterbank values in and averages out.
interface fbd_in_if;
    logic                            valid;
    logic                            ready;
    logic [fbd_pkg::SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface fbd_out_if;
    logic                      valid;
    logic                      ready;
    logic [fbd_pkg::AVG_W-1:0] average_value;
    logic [fbd_pkg::POS_W-1:0] out_channel;
    logic [fbd_pkg::IF_W-1:0]  out_if;
    logic                      last_of_spectrum;

    modport source (output valid, output average_value, output out_channel,
                    output out_if, output last_of_spectrum, input ready);
    modport sink   (input valid, input average_value, input out_channel,
                    input out_if, input last_of_spectrum, output ready);
endinterface

### rtl/core/fbd_ram.sv
// Generic simple dual-port RAM with registered read.
module fbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/fbd_ctrl.sv
// Sequencer for accept, store update, division and result hand-off.
module fbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fbd_pkg::t_status i_status,
    output fbd_pkg::t_cmd    o_cmd
);
    import fbd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.in_valid && i_status.group_done) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                n_state = i_status.emit_pending ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.take_in = 1'b1;
            S_RMW: begin
                // a finished time group goes to the divider, otherwise write back
                if (i_status.emit_pending) begin
                    o_cmd.div_load = 1'b1;
                end else begin
                    o_cmd.store_we = 1'b1;
                end
            end
            S_DIV:  o_cmd.div_step = 1'b1;
            S_PUSH: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/core/fbd_datapath.sv
// Counters, time-sum store, restoring divider and output register.
module fbd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  fbd_pkg::t_cmd                   i_cmd,
    output fbd_pkg::t_status                o_status,
    fbd_in_if.sink                          i_in,
    fbd_out_if.source                       o_out
);
    import fbd_pkg::*;

    // configuration, held already clamped
    logic [CHAN_GROUP_W-1:0] r_chans;
    logic [SAMP_GROUP_W-1:0] r_samps;
    logic [CHANNELS_W-1:0]   r_nchan;
    logic [IFS_W-1:0]        r_nif;
    logic [CHAN_GROUP_W-1:0] n_chans_cfg;
    logic [SAMP_GROUP_W-1:0] n_samps_cfg;
    logic [CHANNELS_W-1:0]   n_nchan_cfg;
    logic [IFS_W-1:0]        n_nif_cfg;

    // stream position
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [IF_W-1:0]   r_ifp,    n_ifp;
    logic [GCC_W-1:0]  r_gcc,    n_gcc;
    logic [GSC_W-1:0]  r_gsc,    n_gsc;
    logic [GSUM_W-1:0] r_gsum,   n_gsum;
    logic [POS_W-1:0]  r_och,    n_och;
    logic [POS_W-1:0]  r_gstart, n_gstart;

    // item that closed a channel group
    logic [GSUM_W-1:0] r_pend_sum;
    logic [ADDR_W-1:0] r_addr;
    logic              r_first;
    logic              r_emit;
    logic [POS_W-1:0]  r_res_och;
    logic [IF_W-1:0]   r_res_if;
    logic              r_res_last;

    // divider
    logic [DIVISOR_W-1:0] r_rem;
    logic [QUOT_W-1:0]    r_q;
    logic [DIVISOR_W-1:0] r_dvsr;
    logic [DIV_CNT_W-1:0] r_cnt;

    // output register
    logic              r_out_valid;
    logic [AVG_W-1:0]  r_avg;
    logic [POS_W-1:0]  r_out_och;
    logic [IF_W-1:0]   r_out_if;
    logic              r_out_last;

    logic                  acc;
    logic [CHANNELS_W:0]   sum_gs;
    logic [CHANNELS_W:0]   sum_gs2;
    logic                  in_group;
    logic                  gcc_full;
    logic                  group_done;
    logic                  emit;
    logic                  last;
    logic                  pos_wrap;
    logic                  if_wrap;
    logic [GSUM_W-1:0]     gsum_add;
    logic [TSUM_W-1:0]     rdata;
    logic [TSUM_W-1:0]     total;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic                  out_free;

    always_comb begin
        logic [CHAN_GROUP_W-1:0] d_chans;
        logic [SAMP_GROUP_W-1:0] d_samps;
        logic [IFS_W-1:0]        d_nif;
        d_chans = i_cfg_data[CHAN_GROUP_W-1:0];
        d_samps = i_cfg_data[SAMP_GROUP_W-1:0];
        d_nif   = i_cfg_data[IFS_W-1:0];
        n_chans_cfg = (d_chans == '0) ? CHAN_GROUP_W'(1)
                    : (d_chans > MAX_CHAN_GROUP) ? MAX_CHAN_GROUP : d_chans;
        n_samps_cfg = (d_samps == '0) ? SAMP_GROUP_W'(1)
                    : (d_samps > MAX_SAMP_GROUP) ? MAX_SAMP_GROUP : d_samps;
        n_nchan_cfg = (i_cfg_data == '0) ? CHANNELS_W'(1)
                    : (i_cfg_data > MAX_CHANNELS) ? MAX_CHANNELS : i_cfg_data;
        n_nif_cfg   = (d_nif == '0) ? IFS_W'(1)
                    : (d_nif > MAX_IFS) ? MAX_IFS : d_nif;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans <= CHAN_GROUP_W'(1);
            r_samps <= SAMP_GROUP_W'(1);
            r_nchan <= MAX_CHANNELS;
            r_nif   <= IFS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANS: r_chans <= n_chans_cfg;
                CFG_SAMPS: r_samps <= n_samps_cfg;
                CFG_NCHAN: r_nchan <= n_nchan_cfg;
                CFG_NIF:   r_nif   <= n_nif_cfg;
                default:   r_nif   <= r_nif;
            endcase
        end
    end

    assign acc      = i_in.valid && i_cmd.take_in;
    assign i_in.ready = i_cmd.take_in;

    // a group fits while its end stays within the channel count
    assign sum_gs   = (CHANNELS_W+1)'(r_gstart) + (CHANNELS_W+1)'(r_chans);
    assign sum_gs2  = sum_gs + (CHANNELS_W+1)'(r_chans);
    assign in_group = sum_gs <= (CHANNELS_W+1)'(r_nchan);
    assign gcc_full = (CHAN_GROUP_W'(r_gcc) + CHAN_GROUP_W'(1)) >= r_chans;
    assign group_done = in_group && gcc_full;
    assign emit     = (SAMP_GROUP_W'(r_gsc) + SAMP_GROUP_W'(1)) >= r_samps;
    assign if_wrap  = (IFS_W'(r_ifp) + IFS_W'(1)) >= r_nif;
    assign last     = (sum_gs2 > (CHANNELS_W+1)'(r_nchan)) && if_wrap;
    assign pos_wrap = (CHANNELS_W'(r_pos) + CHANNELS_W'(1)) >= r_nchan;
    assign gsum_add = r_gsum + GSUM_W'(i_in.sample_value);

    always_comb begin
        n_pos    = r_pos;
        n_ifp    = r_ifp;
        n_gcc    = r_gcc;
        n_gsc    = r_gsc;
        n_gsum   = r_gsum;
        n_och    = r_och;
        n_gstart = r_gstart;
        if (in_group) begin
            if (gcc_full) begin
                n_gsum   = '0;
                n_gcc    = '0;
                n_och    = r_och + POS_W'(1);
                n_gstart = sum_gs[POS_W-1:0];
            end else begin
                n_gsum = gsum_add;
                n_gcc  = r_gcc + GCC_W'(1);
            end
        end
        if (pos_wrap) begin
            n_pos    = '0;
            n_gcc    = '0;
            n_gsum   = '0;
            n_och    = '0;
            n_gstart = '0;
            if (if_wrap) begin
                n_ifp = '0;
                n_gsc = emit ? '0 : r_gsc + GSC_W'(1);
            end else begin
                n_ifp = r_ifp + IF_W'(1);
            end
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_ifp    <= '0;
            r_gcc    <= '0;
            r_gsc    <= '0;
            r_gsum   <= '0;
            r_och    <= '0;
            r_gstart <= '0;
        end else if (i_cfg_we) begin
            // restart at the head of a spectrum and a time group
            r_pos    <= '0;
            r_ifp    <= '0;
            r_gcc    <= '0;
            r_gsc    <= '0;
            r_gsum   <= '0;
            r_och    <= '0;
            r_gstart <= '0;
        end else if (acc) begin
            r_pos    <= n_pos;
            r_ifp    <= n_ifp;
            r_gcc    <= n_gcc;
            r_gsc    <= n_gsc;
            r_gsum   <= n_gsum;
            r_och    <= n_och;
            r_gstart <= n_gstart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && group_done) begin
            r_pend_sum <= gsum_add;
            r_addr     <= {r_ifp, r_och};
            r_first    <= (r_gsc == '0);
            r_emit     <= emit;
            r_res_och  <= r_och;
            r_res_if   <= r_ifp;
            r_res_last <= last;
        end
    end

    fbd_ram #(
        .WIDTH (TSUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_we),
        .i_waddr (r_addr),
        .i_wdata (total),
        .i_raddr ({r_ifp, r_och}),
        .o_rdata (rdata)
    );

    // first spectrum of a time group overwrites: the entry is never read unwritten
    assign total = TSUM_W'(r_pend_sum) + (r_first ? TSUM_W'(0) : rdata);

    // restoring division of (total << 8), one quotient bit a cycle
    assign trial = {r_rem, r_q[QUOT_W-1]};
    assign ge    = trial >= (DIVISOR_W+1)'(r_dvsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_cnt <= DIV_CNT_W'(QUOT_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem  <= DIVISOR_W'(total[TSUM_W-1:QUOT_W-8]);
            r_q    <= {total[QUOT_W-9:0], 8'd0};
            r_dvsr <= DIVISOR_W'(r_chans * r_samps);
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? DIVISOR_W'(trial - (DIVISOR_W+1)'(r_dvsr))
                        : trial[DIVISOR_W-1:0];
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg      <= r_q;
            r_out_och  <= r_res_och;
            r_out_if   <= r_res_if;
            r_out_last <= r_res_last;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.average_value    = r_avg;
    assign o_out.out_channel      = r_out_och;
    assign o_out.out_if           = r_out_if;
    assign o_out.last_of_spectrum = r_out_last;

    assign o_status.in_valid     = i_in.valid;
    assign o_status.group_done   = group_done;
    assign o_status.emit_pending = r_emit;
    assign o_status.div_last     = (r_cnt == DIV_CNT_W'(1));
    assign o_status.out_free     = out_free;

    a_rmw_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && group_done) |=> (i_cmd.store_we || i_cmd.div_load))
        else $error("closed channel group not followed by store update");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_out.ready))
        else $error("result loaded over an untaken result");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("divider stepped past its last quotient bit");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.store_we || i_cmd.div_load) |-> !acc)
        else $error("beat accepted during store update");

endmodule

### rtl/core/filterbank_decimator_core.sv
// Top level of the filterbank integrate-and-dump decimator.
//
//  channel   dir  payload                                           handshake
//  i_in      in   sample_value[15:0]                                valid/ready
//  o_out     out  average_value[23:0] out_channel[11:0] out_if[1:0] valid/ready
//                 last_of_spectrum
//  i_cfg_*   in   index[1:0] data[12:0]                             write enable
//
//  A beat that leaves its channel group open keeps the sequencer idle; one that
//  closes a group is followed by a registered store read, then add and write back.
//  A beat that closes a time group runs the store read, add and divider load,
//  24 steps of the one-bit-a-cycle divider, and the load into the output
//  register.
//  Reset is synchronous; the time-sum store is not cleared, as the first
//  spectrum of each time group writes its entries before any read.
//  The output register lets beats be accepted while a result waits; a further
//  result holds the sequencer until the waiting one is taken.
module filterbank_decimator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fbd_in_if.sink                          i_in,
    fbd_out_if.source                       o_out
);
    import fbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    fbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule
